/* design/pttg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pttg_pkg
// Shared types and constants for the planar tile to gray pixel decoder.
// ----------------------------------------------------------------------------
package pttg_pkg;

  // Bits-per-pixel mode codes; the unused code three decodes as 8bpp.
  localparam logic [1:0] MODE_2BPP = 2'd0;
  localparam logic [1:0] MODE_4BPP = 2'd1;
  localparam logic [1:0] MODE_8BPP = 2'd2;

  // Gray scale factors that stretch a color index to the 0..255 range.
  localparam logic [7:0] GRAY_SCALE_2BPP = 8'h55;
  localparam logic [7:0] GRAY_SCALE_4BPP = 8'h11;
  localparam logic [7:0] GRAY_SCALE_8BPP = 8'h01;

  // Input word: one video memory byte.
  typedef struct packed {
    logic [7:0] vram_byte;
    logic       frame_start;
  } in_word_t;

  // Output word: one gray pixel with canvas coordinates.
  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [7:0] gray_level;
    logic       last_in_run;
  } out_word_t;

  // One decoded tile row: eight plane bytes, plane k in bits 8k+7..8k.
  typedef struct packed {
    logic [63:0] planes;
    logic [1:0]  emode;
    logic [5:0]  tile_col;
    logic [8:0]  pixel_y;
  } row_word_t;

endpackage

`default_nettype wire

/* design/pttg_trk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pttg_trk
// Tile position tracker and plane byte store. Places each byte in its tile
// row and hands out a complete row of plane bytes when its last byte lands.
// ----------------------------------------------------------------------------
module pttg_trk
  import pttg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire in_word_t  in_word,
  input  wire logic [1:0] mode,
  output logic           row_valid,
  output row_word_t      row_word
);

  localparam int NUM_ROWS = 8;

  logic [5:0]  byte_in_tile_r, byte_in_tile_nxt;
  logic [5:0]  tile_col_r, tile_col_nxt;
  logic [5:0]  tile_row_r, tile_row_nxt;
  logic [63:0] store_r [NUM_ROWS];

  logic [1:0]  emode;
  logic [5:0]  size_mask;
  logic [5:0]  col_last;
  logic [5:0]  row_last;
  logic [5:0]  base_byte;
  logic [5:0]  base_col;
  logic [5:0]  base_row;
  logic [5:0]  e;
  logic        upper_pair;
  logic        complete;
  logic [2:0]  wr_row;
  logic [2:0]  wr_lane;
  logic [63:0] merged;

  // Mode decode: tile size mask and grid limits.
  always_comb begin
    emode = (mode == MODE_2BPP) ? MODE_2BPP :
            (mode == MODE_4BPP) ? MODE_4BPP : MODE_8BPP;
    case (emode)
      MODE_2BPP: begin
        size_mask = 6'h0F;
        col_last  = 6'd63;
        row_last  = 6'd63;
      end
      MODE_4BPP: begin
        size_mask = 6'h1F;
        col_last  = 6'd63;
        row_last  = 6'd31;
      end
      default: begin
        size_mask = 6'h3F;
        col_last  = 6'd31;
        row_last  = 6'd31;
      end
    endcase
  end

  // Effective byte index and row completion test.
  always_comb begin
    base_byte = in_word.frame_start ? 6'd0 : byte_in_tile_r;
    base_col  = in_word.frame_start ? 6'd0 : tile_col_r;
    base_row  = in_word.frame_start ? 6'd0 : tile_row_r;
    e         = base_byte & size_mask;
    case (emode)
      MODE_2BPP: upper_pair = 1'b1;
      MODE_4BPP: upper_pair = e[4];
      default:   upper_pair = &e[5:4];
    endcase
    complete = e[0] & upper_pair;
    wr_row   = e[3:1];
    wr_lane  = {e[5:4], e[0]};
    merged   = store_r[wr_row];
    merged[{wr_lane, 3'b000} +: 8] = in_word.vram_byte;
  end

  // Byte counter and tile position advance.
  always_comb begin
    if (e == size_mask) begin
      byte_in_tile_nxt = 6'd0;
      if (base_col >= col_last) begin
        tile_col_nxt = 6'd0;
        tile_row_nxt = (base_row >= row_last) ? 6'd0 : base_row + 6'd1;
      end else begin
        tile_col_nxt = base_col + 6'd1;
        tile_row_nxt = base_row;
      end
    end else begin
      byte_in_tile_nxt = e + 6'd1;
      tile_col_nxt     = base_col;
      tile_row_nxt     = base_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_tile_r <= '0;
      tile_col_r     <= '0;
      tile_row_r     <= '0;
    end else if (accept) begin
      byte_in_tile_r <= byte_in_tile_nxt;
      tile_col_r     <= tile_col_nxt;
      tile_row_r     <= tile_row_nxt;
    end
  end

  // Plane byte store, one 64-bit entry per tile row.
  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[wr_row] <= merged;
    end
  end

  // The finished row includes the byte arriving now.
  assign row_valid         = accept & complete;
  assign row_word.planes   = merged;
  assign row_word.emode    = emode;
  assign row_word.tile_col = base_col;
  assign row_word.pixel_y  = {base_row, wr_row};

endmodule

`default_nettype wire

/* design/pttg_pix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pttg_pix
// Row holding register and pixel serializer. Shifts one decoded row out as
// eight gray pixels via the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pttg_pix
  import pttg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      row_valid,
  input  wire row_word_t row_word,
  output logic           hold_full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      hold_valid_r, hold_valid_nxt;
  row_word_t hold_r;
  logic      ser_valid_r, ser_valid_nxt;
  row_word_t ser_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r;

  logic      out_take;
  logic      ser_done;
  logic      hold_move;
  logic [7:0] plane_mask;
  logic [7:0] scale;
  logic [7:0] color;
  logic [15:0] gray_full;
  out_word_t pixel;

  // Pixel build: bit k of the index is bit 7-x of plane k.
  always_comb begin
    case (ser_r.emode)
      MODE_2BPP: begin
        plane_mask = 8'h03;
        scale      = GRAY_SCALE_2BPP;
      end
      MODE_4BPP: begin
        plane_mask = 8'h0F;
        scale      = GRAY_SCALE_4BPP;
      end
      default: begin
        plane_mask = 8'hFF;
        scale      = GRAY_SCALE_8BPP;
      end
    endcase
    for (int k = 0; k < 8; k++) begin
      color[k] = ser_r.planes[{3'(k), ~cnt_r}];
    end
    color = color & plane_mask;
    gray_full = color * scale;
    pixel.pixel_x     = {ser_r.tile_col, cnt_r};
    pixel.pixel_y     = ser_r.pixel_y;
    pixel.gray_level  = gray_full[7:0];
    pixel.last_in_run = &cnt_r;
  end

  // Handoff control between holding register, serializer and output.
  always_comb begin
    out_take  = !out_valid_r || !out_stall;
    ser_done  = ser_valid_r && out_take && (&cnt_r);
    hold_move = hold_valid_r && (!ser_valid_r || ser_done);

    hold_valid_nxt = hold_valid_r;
    if (row_valid) begin
      hold_valid_nxt = 1'b1;
    end else if (hold_move) begin
      hold_valid_nxt = 1'b0;
    end

    ser_valid_nxt = ser_valid_r;
    cnt_nxt       = cnt_r;
    if (hold_move) begin
      ser_valid_nxt = 1'b1;
      cnt_nxt       = 3'd0;
    end else if (ser_done) begin
      ser_valid_nxt = 1'b0;
    end else if (ser_valid_r && out_take) begin
      cnt_nxt = cnt_r + 3'd1;
    end

    out_valid_nxt = out_take ? ser_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      ser_valid_r  <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      ser_valid_r  <= ser_valid_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (row_valid) begin
      hold_r <= row_word;
    end
    if (hold_move) begin
      ser_r <= hold_r;
    end
    if (out_take && ser_valid_r) begin
      out_r <= pixel;
    end
  end

  assign hold_full = hold_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire

/* design/planar_tile_to_gray_pixels_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// planar_tile_to_gray_pixels_core
// Decodes planar 2/4/8bpp tiles from a video memory byte stream into gray
// pixels with canvas coordinates.
// ----------------------------------------------------------------------------
// Each accepted byte is placed in an eight-row plane store; the byte that
// completes a tile row releases that row, which passes through the holding
// register and the serializer into the output register and leaves it as
// eight pixels, one per cycle while out_stall is low. The single output
// register and the one pixel per cycle serializer set the sustained input
// rate, which depends on how many plane bytes make up a row in each mode.
// Bytes that do not finish a row pass at one per cycle while in_stall is
// low. One finished row can wait in a holding register while the
// previous one shifts out; while it waits, in_stall is high. The mode
// register may be written only while no pixels are pending.
// ----------------------------------------------------------------------------
module planar_tile_to_gray_pixels_core
  import pttg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data
);

  logic [1:0] mode_r;
  logic       in_accept;
  logic       row_valid;
  row_word_t  row_word;
  logic       hold_full;

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_2BPP;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Input stalls while a finished row waits for the serializer.
  assign in_stall  = hold_full;
  assign in_accept = in_valid && !in_stall;

  pttg_trk u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_word   (in_word),
    .mode      (mode_r),
    .row_valid (row_valid),
    .row_word  (row_word)
  );

  pttg_pix u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_word  (row_word),
    .hold_full (hold_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // The run marker sits on the pixel in column seven of the tile.
  a_last_marks_col7: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last_in_run == (out_word.pixel_x[2:0] == 3'h7)))
    else $error("last_in_run does not match pixel column");

  // A completed row always parks in the holding register first.
  a_row_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && row_valid) |=> in_stall)
    else $error("completed row did not reach the holding register");

  // Pixels of one row leave without a gap once the output moves.
  a_row_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_word.last_in_run) |=> out_valid)
    else $error("gap inside an emitted pixel row");

endmodule

`default_nettype wire
